[rtl/core/ispm_pkg.sv]
`timescale 1ns / 1ps
package ispm_pkg;

    localparam int ScanHistoryDef  = 8;
    localparam int SleepDelayMsDef = 100;

    localparam logic [1:0] ST_ACTIVE = 2'd0;
    localparam logic [1:0] ST_LIGHT  = 2'd1;
    localparam logic [1:0] ST_MODEM  = 2'd2;

    localparam logic [3:0] OP_TICK      = 4'd0;
    localparam logic [3:0] OP_LINK_UP   = 4'd1;
    localparam logic [3:0] OP_LINK_DOWN = 4'd2;
    localparam logic [3:0] OP_MSG_UP    = 4'd3;
    localparam logic [3:0] OP_MSG_DOWN  = 4'd4;
    localparam logic [3:0] OP_CARD      = 4'd5;
    localparam logic [3:0] OP_MESSAGE   = 4'd6;
    localparam logic [3:0] OP_NFC_READY = 4'd7;
    localparam logic [3:0] OP_AP_ON     = 4'd8;
    localparam logic [3:0] OP_AP_OFF    = 4'd9;
    localparam logic [3:0] OP_UPD_START = 4'd10;
    localparam logic [3:0] OP_UPD_DONE  = 4'd11;
    localparam logic [3:0] OP_UPD_ERROR = 4'd12;

    localparam logic [2:0] BLK_NONE    = 3'd0;
    localparam logic [2:0] BLK_AP      = 3'd2;
    localparam logic [2:0] BLK_UPDATE  = 3'd3;
    localparam logic [2:0] BLK_OFFLINE = 3'd4;

    localparam logic [2:0] REG_CONTROL    = 3'd0;
    localparam logic [2:0] REG_IDLE_TO    = 3'd1;
    localparam logic [2:0] REG_MODEM_TO   = 3'd2;
    localparam logic [2:0] REG_BURST_HOLD = 3'd3;
    localparam logic [2:0] REG_BURST_WIN  = 3'd4;
    localparam logic [2:0] REG_BURST_CNT  = 3'd5;
    localparam logic [2:0] REG_READY_HOLD = 3'd6;
    localparam logic [2:0] REG_READER_SLP = 3'd7;

    typedef enum logic [1:0] {
        t_IDLE,
        t_SCAN,
        t_EVAL,
        t_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the accepted event
        logic scan;     // examine one ring entry
        logic eval;     // apply the event to state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_card;
        logic scan_last;
    } t_status;

endpackage

[rtl/core/ispm_if.sv]
`timescale 1ns / 1ps
interface ispm_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [31:0] now_ms;
    logic        offline_pending;
    modport source (output valid, op, now_ms, offline_pending, input ready);
    modport sink   (input valid, op, now_ms, offline_pending, output ready);
endinterface

interface ispm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] power_state;
    logic [1:0] previous_state;
    logic       reader_mode;
    logic       state_change_event;
    logic       sleep_request_event;
    logic [1:0] requested_state;
    logic [2:0] block_reason;
    logic       burst_active;
    modport source (output valid, power_state, previous_state, reader_mode,
        state_change_event, sleep_request_event, requested_state, block_reason,
        burst_active, input ready);
    modport sink (input valid, power_state, previous_state, reader_mode,
        state_change_event, sleep_request_event, requested_state, block_reason,
        burst_active, output ready);
endinterface

[rtl/core/ispm_ctrl.sv]
`timescale 1ns / 1ps
module ispm_ctrl
    import ispm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            t_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = t_SCAN;
                end
            end
            t_SCAN: begin
                if (!i_status.is_card) begin
                    n_state = t_EVAL;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_status.scan_last) n_state = t_EVAL;
                end
            end
            t_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = t_DONE;
            end
            t_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = t_IDLE;
                end
            end
            default: n_state = t_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_eval_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.eval |=> o_out_valid) else $error("eval not followed by result");
    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_in_ready) else $error("accept while busy");
    a_give_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> o_in_ready) else $error("no return to idle");
`endif
endmodule

[rtl/core/ispm_dp.sv]
`timescale 1ns / 1ps
module ispm_dp
    import ispm_pkg::*;
#(
    parameter int SCAN_HISTORY   = ScanHistoryDef,
    parameter int SLEEP_DELAY_MS = SleepDelayMsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic [3:0]  i_op,
    input  logic [31:0] i_now_ms,
    input  logic        i_offline,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [1:0]  o_power_state,
    output logic [1:0]  o_previous_state,
    output logic        o_reader_mode,
    output logic        o_change,
    output logic        o_request,
    output logic [1:0]  o_requested,
    output logic [2:0]  o_block,
    output logic        o_burst
);
    localparam int PW = (SCAN_HISTORY > 1) ? $clog2(SCAN_HISTORY) : 1;
    localparam int CW = $clog2(SCAN_HISTORY + 1);
    localparam logic [PW-1:0] PLast = PW'(SCAN_HISTORY - 1);

    logic [7:0]  r_ctl;
    logic [31:0] r_idle_to, r_modem_to, r_bhold, r_bwin, r_rhold, r_rsleep;
    logic [3:0]  r_bcnt;

    logic [1:0]  r_pstate, r_prev;
    logic        r_rmode, r_burst, r_pend, r_msg, r_ap, r_upd;
    logic [1:0]  r_pend_st;
    logic [31:0] r_req_t, r_act_t, r_card_t;
    logic [31:0] r_ring [SCAN_HISTORY];
    logic [SCAN_HISTORY-1:0] r_ring_v;
    logic [PW-1:0] r_ptr, r_idx;
    logic [CW-1:0] r_count;

    logic [3:0]  r_op;
    logic [31:0] r_t;
    logic        r_off;
    logic        r_change, r_request, r_obs;
    logic [1:0]  r_requested;
    logic [2:0]  r_block;

    assign o_status.is_card   = (r_op == OP_CARD);
    assign o_status.scan_last = (r_idx == PLast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= 8'd1; r_idle_to <= 32'd30000; r_modem_to <= 32'd300000;
            r_bhold <= 32'd10000; r_bwin <= 32'd5000; r_bcnt <= 4'd3;
            r_rhold <= 32'd3000; r_rsleep <= 32'd10000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CONTROL:    r_ctl      <= i_cfg_data[7:0];
                REG_IDLE_TO:    r_idle_to  <= i_cfg_data;
                REG_MODEM_TO:   r_modem_to <= i_cfg_data;
                REG_BURST_HOLD: r_bhold    <= i_cfg_data;
                REG_BURST_WIN:  r_bwin     <= i_cfg_data;
                REG_BURST_CNT:  r_bcnt     <= i_cfg_data[3:0];
                REG_READY_HOLD: r_rhold    <= i_cfg_data;
                REG_READER_SLP: r_rsleep   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Ring entries: the one being written counts as the new time (scan happens first).
    logic [31:0] w_entry;
    logic        w_evalid;
    always_comb begin
        if (r_idx == r_ptr) begin
            w_entry = r_t; w_evalid = 1'b1;
        end else begin
            w_entry = r_ring[r_idx]; w_evalid = r_ring_v[r_idx];
        end
    end
    wire w_hit = w_evalid && (w_entry != 32'd0) && ((r_t - w_entry) <= r_bwin);

    // Event evaluation: sequential rendering of the step with local variables.
    logic [1:0]  v_ps, v_pend_st, v_want;
    logic        v_rm, v_burst, v_pend, v_msg, v_ap, v_upd, v_chg, v_req, v_hold;
    logic [1:0]  v_reqd;
    logic [2:0]  v_blk;
    logic [31:0] v_req_t, v_act_t, v_card_t, v_idle;
    logic [3:0]  v_thr;
    logic        v_wr, v_do_wake, v_ask;
    logic [1:0]  v_ask_s;

    function automatic logic f_rd(input logic [7:0] ctl, input logic [1:0] ps,
            input logic burst, input logic hold, input logic [31:0] since,
            input logic [31:0] lim);
        logic r;
        if (!ctl[2]) r = 1'b0;
        else if (ps == ST_MODEM) r = 1'b1;
        else if (!ctl[0]) r = 1'b0;
        else if (burst || hold) r = 1'b0;
        else if (since < lim) r = 1'b0;
        else r = 1'b1;
        return r;
    endfunction

    always_comb begin
        v_ps = r_pstate; v_rm = r_rmode; v_burst = r_burst;
        v_pend = r_pend; v_pend_st = r_pend_st; v_msg = r_msg; v_ap = r_ap;
        v_upd = r_upd; v_chg = 1'b0; v_req = 1'b0; v_reqd = ST_ACTIVE;
        v_blk = BLK_NONE; v_req_t = r_req_t; v_act_t = r_act_t; v_card_t = r_card_t;
        v_want = ST_ACTIVE; v_do_wake = 1'b0; v_ask = 1'b0; v_ask_s = ST_ACTIVE;
        v_thr = (r_bcnt == 4'd0) ? 4'd1 : r_bcnt;
        v_idle = r_t - r_act_t;
        v_hold = 1'b0; v_wr = 1'b0;
        case (r_op)
            OP_TICK: begin
                if (v_burst && ((r_t - v_card_t) >= r_bhold)) v_burst = 1'b0;
                v_hold = (v_card_t != 32'd0) && ((r_t - v_card_t) < r_rhold);
                v_wr = f_rd(r_ctl, v_ps, v_burst, v_hold, r_t - v_card_t, r_rsleep);
                if (v_wr != v_rm) begin v_rm = v_wr; v_chg = 1'b1; end
                if (v_pend) begin
                    if ((r_t - v_req_t) >= 32'(SLEEP_DELAY_MS)) begin
                        v_pend = 1'b0; v_pend_st = ST_ACTIVE;
                        if ((r_pend_st == ST_LIGHT || r_pend_st == ST_MODEM)
                                && r_pend_st != v_ps) begin
                            if (v_ap) v_blk = BLK_AP;
                            else if (v_upd) v_blk = BLK_UPDATE;
                            else if (v_msg && r_off) v_blk = BLK_OFFLINE;
                            else begin
                                v_ps = r_pend_st;
                                if (r_pend_st == ST_MODEM) v_rm = 1'b1;
                                v_chg = 1'b1;
                            end
                        end
                    end
                end else begin
                    if (!r_ctl[0]) v_want = v_ps;
                    else if (v_burst || v_hold) v_want = ST_ACTIVE;
                    else if (v_idle >= r_modem_to) v_want = ST_MODEM;
                    else if (v_idle >= r_idle_to) v_want = ST_LIGHT;
                    else v_want = ST_ACTIVE;
                    if (v_want == ST_ACTIVE) begin
                        if (v_ps != ST_ACTIVE) v_do_wake = 1'b1;
                    end else if (v_want == ST_LIGHT && v_ps == ST_ACTIVE) begin
                        v_ask = 1'b1; v_ask_s = ST_LIGHT;
                    end else if (v_want == ST_MODEM && v_ps != ST_MODEM) begin
                        v_ask = 1'b1; v_ask_s = ST_MODEM;
                    end
                end
            end
            OP_LINK_UP: if (r_ctl[3]) v_act_t = r_t;
            OP_LINK_DOWN: ;
            OP_MSG_UP: begin v_msg = 1'b1; if (r_ctl[4]) v_act_t = r_t; end
            OP_MSG_DOWN: begin
                v_msg = 1'b0;
                v_hold = (v_card_t != 32'd0) && ((r_t - v_card_t) < r_rhold);
                if (r_ctl[1] && v_ps != ST_MODEM && !(v_burst || v_hold)) begin
                    v_ask = 1'b1; v_ask_s = ST_MODEM;
                end
            end
            OP_CARD: begin
                v_card_t = r_t;
                if (!v_burst && ({{(8-CW){1'b0}}, r_count} >= {4'd0, v_thr}))
                    v_burst = 1'b1;
                v_act_t = r_t;
                v_do_wake = 1'b1;
            end
            OP_MESSAGE:   if (r_ctl[6]) v_act_t = r_t;
            OP_NFC_READY: if (r_ctl[7]) v_act_t = r_t;
            OP_AP_ON:     begin v_ap = 1'b1; v_act_t = r_t; v_do_wake = 1'b1; end
            OP_AP_OFF:    begin v_ap = 1'b0; v_act_t = r_t; end
            OP_UPD_START: begin v_upd = 1'b1; v_act_t = r_t; v_do_wake = 1'b1; end
            OP_UPD_DONE, OP_UPD_ERROR: begin v_upd = 1'b0; v_act_t = r_t; end
            default: ;
        endcase
        if (v_ask && !(v_ps == v_ask_s && !v_pend)) begin
            v_req = 1'b1; v_reqd = v_ask_s; v_pend = 1'b1;
            v_pend_st = v_ask_s; v_req_t = r_t;
        end
        if (v_do_wake) begin
            v_pend = 1'b0; v_pend_st = ST_ACTIVE; v_act_t = r_t;
            v_hold = (v_card_t != 32'd0) && ((r_t - v_card_t) < r_rhold);
            v_wr = f_rd(r_ctl, ST_ACTIVE, v_burst, v_hold, r_t - v_card_t, r_rsleep);
            if (v_ps != ST_ACTIVE) begin
                v_ps = ST_ACTIVE; v_rm = v_wr; v_chg = 1'b1;
            end else if (v_wr != v_rm) begin
                v_rm = v_wr; v_chg = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pstate <= ST_ACTIVE; r_rmode <= 1'b0; r_burst <= 1'b0; r_pend <= 1'b0;
            r_pend_st <= ST_ACTIVE; r_req_t <= '0; r_act_t <= '0; r_card_t <= '0;
            r_ring_v <= '0; r_ptr <= '0; r_msg <= 1'b0; r_ap <= 1'b0; r_upd <= 1'b0;
            r_idx <= '0; r_count <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0; r_count <= '0;
            end
            if (i_cmd.scan) begin
                r_idx <= r_idx + PW'(1);
                if (w_hit) r_count <= r_count + CW'(1);
            end
            if (i_cmd.eval) begin
                r_pstate <= v_ps; r_rmode <= v_rm; r_burst <= v_burst; r_pend <= v_pend;
                r_pend_st <= v_pend_st; r_req_t <= v_req_t; r_act_t <= v_act_t;
                r_card_t <= v_card_t; r_msg <= v_msg; r_ap <= v_ap; r_upd <= v_upd;
                if (r_op == OP_CARD) begin
                    r_ring_v[r_ptr] <= 1'b1;
                    r_ptr <= (r_ptr == PLast) ? '0 : r_ptr + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && r_op == OP_CARD) r_ring[r_ptr] <= r_t;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op; r_t <= i_now_ms; r_off <= i_offline; r_prev <= r_pstate;
        end
        if (i_cmd.eval) begin
            r_change <= v_chg; r_request <= v_req; r_requested <= v_reqd;
            r_block <= v_blk; r_obs <= v_burst;
        end
    end

    assign o_power_state    = r_pstate;
    assign o_previous_state = r_prev;
    assign o_reader_mode    = r_rmode;
    assign o_change         = r_change;
    assign o_request        = r_request;
    assign o_requested      = r_requested;
    assign o_block          = r_block;
    assign o_burst          = r_obs;

`ifndef NO_ASSERTIONS
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PLast) else $error("ring pointer out of range");
    a_pend_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_pend_st == ST_LIGHT || r_pend_st == ST_MODEM))
        else $error("pending without sleep state");
    a_modem_reader: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval && v_ps == ST_MODEM && r_pstate != ST_MODEM |=> r_rmode)
        else $error("modem entry without reader power-down");
`endif
endmodule

[rtl/core/idle_sleep_power_manager.sv]
`timescale 1ns / 1ps
// Idle / sleep power manager.
// Channels: i_evt (sink) carries one timestamped event per transaction: op, now_ms and
// offline_pending. o_res (source) returns exactly one result transaction per event:
// power state before and after, reader chip mode, change and sleep-request flags,
// requested state, block reason and burst flag.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data write one of the eight registers
// per cycle; write only while no event is in flight.
// Sequencing: after accept, a card scan walks the ring entry by entry through the
// single compare unit to count recent scans, then evaluates; all other events pass
// the scan state without walking the ring and go straight to evaluate.
// A new event is accepted the cycle after the result transaction completes, so the
// block never takes a new event before the last one's result has been taken.
// Reset (synchronous, active low): registers take their default values, power state
// active, no pending sleep, scan ring treated as empty through per-entry valid bits.
// When the receiver stalls, the result holds stable and no new event is accepted.
module idle_sleep_power_manager
    import ispm_pkg::*;
#(
    parameter int SCAN_HISTORY   = ScanHistoryDef,
    parameter int SLEEP_DELAY_MS = SleepDelayMsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    ispm_in_if.sink     i_evt,
    ispm_out_if.source  o_res
);
    t_cmd    w_cmd;
    t_status w_status;

    // Sequence load, ring walk, evaluate and result hold.
    ispm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .o_in_ready  (i_evt.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Hold all power-manager state and the scan ring.
    ispm_dp #(
        .SCAN_HISTORY   (SCAN_HISTORY),
        .SLEEP_DELAY_MS (SLEEP_DELAY_MS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_op             (i_evt.op),
        .i_now_ms         (i_evt.now_ms),
        .i_offline        (i_evt.offline_pending),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_power_state    (o_res.power_state),
        .o_previous_state (o_res.previous_state),
        .o_reader_mode    (o_res.reader_mode),
        .o_change         (o_res.state_change_event),
        .o_request        (o_res.sleep_request_event),
        .o_requested      (o_res.requested_state),
        .o_block          (o_res.block_reason),
        .o_burst          (o_res.burst_active)
    );
endmodule

[bench/idle_sleep_power_manager_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the idle / sleep power manager.
// Drive events on the input channel at the falling edge and check every result
// transaction at the rising edge against an in-bench model of the power logic.
module idle_sleep_power_manager_tb;
    import ispm_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RING_DEPTH   = ScanHistoryDef;
    localparam int WAKE_DELAY   = SleepDelayMsDef;
    localparam int DRAIN_CYCLES = 30;       // well past the longest event latency
    localparam int STALL_LIMIT  = 6000;     // cycles without any transaction
    localparam int HOLDOFF_LEN  = 400;
    localparam int PHASE_ITEMS  = 260;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic [1:0] pwr;
        logic [1:0] prev;
        logic       rdr;
        logic       chg;
        logic       req;
        logic [1:0] req_st;
        logic [2:0] blk;
        logic       burst;
    } t_power_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = REG_CONTROL;
    logic [31:0] i_cfg_data = '0;

    ispm_in_if  evt_ch ();
    ispm_out_if res_ch ();

    idle_sleep_power_manager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_evt       (evt_ch),
        .o_res       (res_ch)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Power model: registers and state mirrored from the block
    // ---------------------------------------------------------------
    bit [7:0]  cfg_ctl;
    bit [31:0] cfg_idle_to, cfg_modem_to, cfg_burst_hold, cfg_burst_win;
    bit [3:0]  cfg_burst_cnt;
    bit [31:0] cfg_ready_hold, cfg_reader_slp;

    bit [1:0]  mdl_state;
    bit        mdl_reader, mdl_burst, mdl_pending;
    bit [1:0]  mdl_pend_state;
    bit [31:0] mdl_req_time, mdl_act_time, mdl_card_time;
    bit [31:0] mdl_ring [RING_DEPTH];
    int        mdl_ring_ptr;
    bit        mdl_msg_up, mdl_ap_on, mdl_upd_run;

    // per-event flags
    bit        ev_chg, ev_req, ev_offline;
    bit [1:0]  ev_req_st;
    bit [2:0]  ev_blk;

    t_power_report expected_reports[$];
    int            err_cnt = 0;
    int            quiet_cycles = 0;
    bit            no_idle = 1'b0;
    bit            holdoff_go = 1'b0;
    bit [31:0]     clock_ms = 0;

    function automatic void reset_power_model();
        cfg_ctl = 8'd1;          cfg_idle_to = 30000;   cfg_modem_to = 300000;
        cfg_burst_hold = 10000;  cfg_burst_win = 5000;  cfg_burst_cnt = 4'd3;
        cfg_ready_hold = 3000;   cfg_reader_slp = 10000;
        mdl_state = ST_ACTIVE;   mdl_reader = 1'b0;     mdl_burst = 1'b0;
        mdl_pending = 1'b0;      mdl_pend_state = ST_ACTIVE;
        mdl_req_time = 0;        mdl_act_time = 0;      mdl_card_time = 0;
        foreach (mdl_ring[i]) mdl_ring[i] = 0;
        mdl_ring_ptr = 0;
        mdl_msg_up = 1'b0;       mdl_ap_on = 1'b0;      mdl_upd_run = 1'b0;
    endfunction

    function automatic bit in_ready_hold(bit [31:0] t);
        bit [31:0] age;
        age = t - mdl_card_time;
        return mdl_card_time != 0 && age < cfg_ready_hold;
    endfunction

    function automatic bit reader_target(bit [31:0] t);
        bit [31:0] age;
        age = t - mdl_card_time;
        if (!cfg_ctl[2]) return 1'b0;
        if (mdl_state == ST_MODEM) return 1'b1;
        if (!cfg_ctl[0]) return 1'b0;
        if (mdl_burst || in_ready_hold(t)) return 1'b0;
        if (age < cfg_reader_slp) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit [1:0] state_target(bit [31:0] t);
        bit [31:0] idle;
        idle = t - mdl_act_time;
        if (!cfg_ctl[0]) return mdl_state;
        if (mdl_burst || in_ready_hold(t)) return ST_ACTIVE;
        if (idle >= cfg_modem_to) return ST_MODEM;
        if (idle >= cfg_idle_to) return ST_LIGHT;
        return ST_ACTIVE;
    endfunction

    function automatic void steer_reader(bit mode);
        if (mode == mdl_reader) return;
        mdl_reader = mode;
        ev_chg = 1'b1;
    endfunction

    function automatic void mark_activity(bit enable, bit [31:0] t);
        if (enable) mdl_act_time = t;
    endfunction

    function automatic void request_sleep(bit [1:0] s, bit [31:0] t);
        if (s == ST_ACTIVE) return;
        if (mdl_state == s && !mdl_pending) return;
        ev_req = 1'b1;
        ev_req_st = s;
        mdl_pending = 1'b1;
        mdl_pend_state = s;
        mdl_req_time = t;
    endfunction

    function automatic void drop_pending();
        mdl_pending = 1'b0;
        mdl_pend_state = ST_ACTIVE;
    endfunction

    function automatic void enter_pending();
        bit [1:0] ps;
        ps = mdl_pend_state;
        drop_pending();
        if (ps != ST_LIGHT && ps != ST_MODEM) return;
        if (ps == mdl_state) return;
        if (mdl_ap_on) begin
            ev_blk = BLK_AP;
            return;
        end
        if (mdl_upd_run) begin
            ev_blk = BLK_UPDATE;
            return;
        end
        if (mdl_msg_up && ev_offline) begin
            ev_blk = BLK_OFFLINE;
            return;
        end
        mdl_state = ps;
        if (ps == ST_MODEM) mdl_reader = 1'b1;
        ev_chg = 1'b1;
    endfunction

    function automatic void wake_up(bit [31:0] t);
        drop_pending();
        if (mdl_state == ST_ACTIVE) begin
            mdl_act_time = t;
            steer_reader(reader_target(t));
            return;
        end
        mdl_state = ST_ACTIVE;
        mdl_reader = reader_target(t);
        ev_chg = 1'b1;
        mdl_act_time = t;
    endfunction

    function automatic void on_tick(bit [31:0] t);
        bit [1:0]  want;
        bit [31:0] quiet, waited;
        quiet = t - mdl_card_time;
        waited = t - mdl_req_time;
        if (mdl_burst && quiet >= cfg_burst_hold) mdl_burst = 1'b0;
        steer_reader(reader_target(t));
        if (mdl_pending) begin
            if (waited >= WAKE_DELAY) enter_pending();
            return;
        end
        want = state_target(t);
        if (want == ST_ACTIVE) begin
            if (mdl_state != ST_ACTIVE) wake_up(t);
            return;
        end
        if (mdl_state == ST_MODEM && want == ST_MODEM) return;
        if (want == ST_LIGHT && mdl_state == ST_ACTIVE) begin
            request_sleep(ST_LIGHT, t);
            return;
        end
        if (want == ST_MODEM && mdl_state != ST_MODEM) request_sleep(ST_MODEM, t);
    endfunction

    function automatic void on_card(bit [31:0] t);
        int        hits;
        int        thr;
        bit [31:0] age;
        hits = 0;
        mdl_card_time = t;
        mdl_ring[mdl_ring_ptr] = t;
        mdl_ring_ptr = (mdl_ring_ptr + 1) % RING_DEPTH;
        thr = (cfg_burst_cnt == 0) ? 1 : int'(cfg_burst_cnt);
        foreach (mdl_ring[i]) begin
            age = t - mdl_ring[i];
            if (mdl_ring[i] != 0 && age <= cfg_burst_win) hits++;
        end
        if (!mdl_burst && hits >= thr) mdl_burst = 1'b1;
        mark_activity(cfg_ctl[5], t);
        wake_up(t);
    endfunction

    // Apply one event and return the report the block must give for it.
    function automatic t_power_report apply_power_event(bit [3:0] op, bit [31:0] t, bit off);
        t_power_report r;
        bit [1:0]      prev;
        prev = mdl_state;
        ev_chg = 1'b0;
        ev_req = 1'b0;
        ev_req_st = ST_ACTIVE;
        ev_blk = BLK_NONE;
        ev_offline = off;
        case (op)
            OP_TICK:      on_tick(t);
            OP_LINK_UP:   mark_activity(cfg_ctl[3], t);
            OP_LINK_DOWN: ;
            OP_MSG_UP: begin
                mdl_msg_up = 1'b1;
                mark_activity(cfg_ctl[4], t);
            end
            OP_MSG_DOWN: begin
                mdl_msg_up = 1'b0;
                if (cfg_ctl[1] && mdl_state != ST_MODEM && !(mdl_burst || in_ready_hold(t)))
                    request_sleep(ST_MODEM, t);
            end
            OP_CARD:      on_card(t);
            OP_MESSAGE:   mark_activity(cfg_ctl[6], t);
            OP_NFC_READY: mark_activity(cfg_ctl[7], t);
            OP_AP_ON: begin
                mdl_ap_on = 1'b1;
                mdl_act_time = t;
                wake_up(t);
            end
            OP_AP_OFF: begin
                mdl_ap_on = 1'b0;
                mdl_act_time = t;
            end
            OP_UPD_START: begin
                mdl_upd_run = 1'b1;
                mdl_act_time = t;
                wake_up(t);
            end
            OP_UPD_DONE, OP_UPD_ERROR: begin
                mdl_upd_run = 1'b0;
                mdl_act_time = t;
            end
            default: ;  // unknown op leaves everything alone
        endcase
        r.pwr = mdl_state;
        r.prev = prev;
        r.rdr = mdl_reader;
        r.chg = ev_chg;
        r.req = ev_req;
        r.req_st = ev_req_st;
        r.blk = ev_blk;
        r.burst = mdl_burst;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Idle-gap shaping: mostly short, a few long
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (no_idle || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    // ---------------------------------------------------------------
    // Event sender: hold valid until the transaction is taken
    // ---------------------------------------------------------------
    task automatic send_event(bit [3:0] op, bit [31:0] t, bit off);
        int            gap;
        t_power_report rep;
        @(negedge i_clk);
        evt_ch.valid <= 1'b1;
        evt_ch.op <= op;
        evt_ch.now_ms <= t;
        evt_ch.offline_pending <= off;
        do @(posedge i_clk); while (!(evt_ch.valid && evt_ch.ready));
        rep = apply_power_event(op, t, off);
        expected_reports = {expected_reports, rep};
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            evt_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid and wait until every report is back and the block is quiet.
    task automatic drain_events();
        @(negedge i_clk);
        evt_ch.valid <= 1'b0;
        wait (expected_reports.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, bit [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_CONTROL:    cfg_ctl = val[7:0];
            REG_IDLE_TO:    cfg_idle_to = val;
            REG_MODEM_TO:   cfg_modem_to = val;
            REG_BURST_HOLD: cfg_burst_hold = val;
            REG_BURST_WIN:  cfg_burst_win = val;
            REG_BURST_CNT:  cfg_burst_cnt = val[3:0];
            REG_READY_HOLD: cfg_ready_hold = val;
            REG_READER_SLP: cfg_reader_slp = val;
            default:        ;
        endcase
    endtask

    task automatic program_all(bit [7:0] ctl, bit [31:0] idle_to, bit [31:0] modem_to,
                               bit [31:0] bhold, bit [31:0] bwin, bit [3:0] bcnt,
                               bit [31:0] rhold, bit [31:0] rslp);
        write_reg(REG_CONTROL, {24'd0, ctl});
        write_reg(REG_IDLE_TO, idle_to);
        write_reg(REG_MODEM_TO, modem_to);
        write_reg(REG_BURST_HOLD, bhold);
        write_reg(REG_BURST_WIN, bwin);
        write_reg(REG_BURST_CNT, {28'd0, bcnt});
        write_reg(REG_READY_HOLD, rhold);
        write_reg(REG_READER_SLP, rslp);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random event mix biased toward ticks and scans so timeouts, bursts and
    // pending sleeps get exercised; time mostly walks forward in small steps.
    task automatic random_events(int count);
        bit [3:0] op;
        int       roll;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 40)      op = OP_TICK;
            else if (roll < 58) op = OP_CARD;
            else if (roll < 96) op = 4'($urandom_range(1, 12));
            else                op = 4'($urandom_range(0, 15));
            roll = $urandom_range(99);
            if (roll < 90)      clock_ms = clock_ms + $urandom_range(0, 1500);
            else if (roll < 97) clock_ms = clock_ms + $urandom_range(0, 400000);
            else                clock_ms = $urandom;
            send_event(op, clock_ms, $urandom_range(99) < 25);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed_defaults();
        send_event(OP_TICK, 0, 1'b0);
        send_event(OP_LINK_DOWN, 5, 1'b1);
        for (int u = 13; u <= 15; u++) send_event(4'(u), 32'hFFFF_FFFF, 1'b1);
        send_event(OP_CARD, 0, 1'b0);               // zero timestamp scan
        // sleep refused while the access point runs
        send_event(OP_AP_ON, 1000, 1'b0);
        send_event(OP_TICK, 40000, 1'b0);
        send_event(OP_TICK, 40100, 1'b0);
        send_event(OP_AP_OFF, 40200, 1'b0);
        // sleep refused during an update
        send_event(OP_UPD_START, 40300, 1'b0);
        send_event(OP_TICK, 80000, 1'b0);
        send_event(OP_TICK, 80100, 1'b0);
        send_event(OP_UPD_DONE, 80200, 1'b0);
        // sleep refused while offline records wait, then granted
        send_event(OP_MSG_UP, 80300, 1'b0);
        send_event(OP_TICK, 120000, 1'b0);
        send_event(OP_TICK, 120200, 1'b1);
        send_event(OP_TICK, 120300, 1'b0);
        send_event(OP_TICK, 120400, 1'b0);
        send_event(OP_UPD_ERROR, 130000, 1'b0);
        send_event(OP_MESSAGE, 140000, 1'b0);
        send_event(OP_NFC_READY, 150000, 1'b0);
        send_event(OP_LINK_UP, 160000, 1'b0);
        send_event(OP_MSG_DOWN, 170000, 1'b1);
        send_event(OP_TICK, 32'hFFFF_FFFF, 1'b0);
        drain_events();
    endtask

    task automatic test_register_extremes();
        program_all(8'h00, 0, 0, 0, 0, 4'd0, 0, 0);
        clock_ms = 32'h8000_0000;
        random_events(40);
        drain_events();
        program_all(8'hFF, '1, '1, '1, '1, 4'd8, '1, '1);
        random_events(40);
        drain_events();
    endtask

    task automatic test_random_settings();
        // short timeouts so light / modem sleep and bursts happen often
        no_idle = 1'b1;
        program_all(8'hFF, 2000, 8000, 3000, 1500, 4'd3, 800, 2500);
        clock_ms = 1;
        random_events(PHASE_ITEMS);
        drain_events();
        no_idle = 1'b0;
        program_all(8'h07, 1500, 5000, 2000, 3000, 4'd1, 0, 4000);
        random_events(PHASE_ITEMS);
        drain_events();
        program_all(8'($urandom), $urandom_range(0, 5000), $urandom_range(0, 20000),
                    $urandom_range(0, 6000), $urandom_range(0, 6000),
                    4'($urandom_range(0, 8)), $urandom_range(0, 3000),
                    $urandom_range(0, 8000));
        random_events(PHASE_ITEMS);
        drain_events();
        // scan count beyond the ring depth never enters burst
        program_all(8'hFD, 3000, 9000, 2500, 4000, 4'd9, 1000, 3000);
        random_events(PHASE_ITEMS / 2);
        drain_events();
        program_all(8'hFB, 3000, 9000, 2500, 4000, 4'd15, 1000, 3000);
        random_events(PHASE_ITEMS / 2);
        drain_events();
        program_all(8'hFF, 30000, 300000, 10000, 5000, 4'd3, 3000, 10000);
        random_events(PHASE_ITEMS);
        drain_events();
    endtask

    task automatic test_result_backpressure();
        program_all(8'hFF, 2000, 8000, 3000, 1500, 4'd2, 800, 2500);
        no_idle = 1'b1;
        holdoff_go = 1'b1;
        random_events(30);
        holdoff_go = 1'b0;
        no_idle = 1'b0;
        drain_events();
    endtask

    initial begin
        evt_ch.valid = 1'b0;
        evt_ch.op = OP_TICK;
        evt_ch.now_ms = '0;
        evt_ch.offline_pending = 1'b0;
        reset_power_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_defaults();
        test_register_extremes();
        test_random_settings();
        test_result_backpressure();

        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off on request
    // ---------------------------------------------------------------
    int  stall_left = 0;
    bit  holdoff_done = 1'b0;

    always @(negedge i_clk) begin
        if (holdoff_go && !holdoff_done) begin
            holdoff_done <= 1'b1;
            stall_left <= HOLDOFF_LEN;
            res_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(99) < 12) begin
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expected report.
    always @(posedge i_clk) begin
        t_power_report want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_reports.pop_front();
                if (res_ch.power_state !== want.pwr)
                    report_mismatch("power_state", res_ch.power_state, want.pwr);
                if (res_ch.previous_state !== want.prev)
                    report_mismatch("previous_state", res_ch.previous_state, want.prev);
                if (res_ch.reader_mode !== want.rdr)
                    report_mismatch("reader_mode", res_ch.reader_mode, want.rdr);
                if (res_ch.state_change_event !== want.chg)
                    report_mismatch("state_change_event", res_ch.state_change_event,
                                    want.chg);
                if (res_ch.sleep_request_event !== want.req)
                    report_mismatch("sleep_request_event", res_ch.sleep_request_event,
                                    want.req);
                if (res_ch.requested_state !== want.req_st)
                    report_mismatch("requested_state", res_ch.requested_state, want.req_st);
                if (res_ch.block_reason !== want.blk)
                    report_mismatch("block_reason", res_ch.block_reason, want.blk);
                if (res_ch.burst_active !== want.burst)
                    report_mismatch("burst_active", res_ch.burst_active, want.burst);
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog expired", $time);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
